// ----- sv/pfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// shared types and constants for the protobuf field encoder
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int CNT_W   = 17;
   localparam int FIELD_W = 29;
   localparam int VALUE_W = 64;
   localparam int TAG_W   = FIELD_W + 3;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_VARINT  = 2'd1,
      OP_LENGTH  = 2'd2,
      OP_PAYLOAD = 2'd3
   } op_type;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_LENGTH = 3'd2;

   localparam logic [16:0] CAP_RESET = 17'd65536;

   // one classified word waiting between front and back
   typedef struct packed {
      op_type               op;
      logic [TAG_W-1:0]     tag;
      logic [VALUE_W-1:0]   value;
      logic [7:0]           pbyte;
   } entry_type;

endpackage

// ----- sv/pfe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_front
// classifies an incoming word and forms its wire tag
// ----------------------------------------------------------------------------
module pfe_front (
   input  logic [1:0]                    req_opcode,
   input  logic [pfe_pkg::FIELD_W-1:0]   req_field_number,
   input  logic [pfe_pkg::VALUE_W-1:0]   req_value,
   input  logic [7:0]                    req_payload_byte,
   output pfe_pkg::entry_type            entry
);
   import pfe_pkg::*;

   op_type     op;
   logic [2:0] wire_type;

   assign op = op_type'(req_opcode);

   always_comb begin
      unique case (op)
         OP_LENGTH: wire_type = WT_LENGTH;
         default:   wire_type = WT_VARINT;
      endcase
   end

   assign entry.op    = op;
   assign entry.tag   = {req_field_number, wire_type};
   assign entry.value = req_value;
   assign entry.pbyte = req_payload_byte;

endmodule

// ----- sv/pfe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module pfe_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pfe_pkg::entry_type    push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pfe_pkg::entry_type    pop_data
);
   import pfe_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/pfe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_back
// varint sequencer: one output byte per cycle unless rsp_ready stalls it, with capacity check
// ----------------------------------------------------------------------------
module pfe_back #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pfe_pkg::CNT_W-1:0]   capacity,
   input  logic                        head_valid,
   output logic                        head_ready,
   input  pfe_pkg::entry_type          head,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_overflow,
   output logic [pfe_pkg::CNT_W-1:0]   rsp_byte_count
);
   import pfe_pkg::*;

   typedef enum logic {ST_IDLE, ST_BUSY} state_type;

   state_type          state_ff;
   logic [VALUE_W-1:0] shreg_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               phase_ff;     // 0 tag, 1 value
   logic               has_val_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               failed_ff;
   logic               rsp_valid_ff;
   logic [7:0]         out_byte_ff;
   logic               last_ff;
   logic               ovf_ff;
   logic [CNT_W-1:0]   byte_count_ff;

   logic               busy, raw, more, full, slot_free, fire, head_start;
   logic               cur_phase, cur_has_val;
   logic [VALUE_W-1:0] work, cur_value;
   logic [7:0]         byte_val;
   logic [CNT_W-1:0]   count_inc;

   assign busy       = (state_ff == ST_BUSY);
   assign head_start = head_valid && (head.op == OP_START);
   assign raw        = !busy && (head.op == OP_PAYLOAD);
   assign work       = busy ? shreg_ff :
                       (raw ? VALUE_W'(head.pbyte) : VALUE_W'(head.tag));
   assign more       = !raw && (work[VALUE_W-1:7] != '0);
   assign byte_val   = raw ? head.pbyte : {more, work[6:0]};
   assign cur_phase   = busy ? phase_ff   : 1'b0;
   assign cur_has_val = busy ? has_val_ff : (head.op != OP_PAYLOAD);
   assign cur_value   = busy ? value_ff   : head.value;
   assign full       = (count_ff >= capacity) ||
                       (32'(count_ff) >= 32'(MAX_BUFFER_BYTES));
   assign count_inc  = count_ff + CNT_W'(1);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign fire       = slot_free && (busy || (head_valid && !head_start));
   assign head_ready = !busy && (head_start || slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (!busy && head_start) begin
            count_ff  <= '0;
            failed_ff <= 1'b0;
         end else if (fire) begin
            if (!busy) begin
               value_ff   <= head.value;
               has_val_ff <= cur_has_val;
            end
            priority if (!busy && failed_ff) begin
               out_byte_ff   <= '0;
               last_ff       <= 1'b1;
               ovf_ff        <= 1'b1;
               byte_count_ff <= count_ff;
            end else if (full) begin
               out_byte_ff   <= '0;
               last_ff       <= 1'b1;
               ovf_ff        <= 1'b1;
               byte_count_ff <= count_ff;
               failed_ff     <= 1'b1;
               state_ff      <= ST_IDLE;
            end else begin
               out_byte_ff   <= byte_val;
               ovf_ff        <= 1'b0;
               byte_count_ff <= count_inc;
               count_ff      <= count_inc;
               priority if (more) begin
                  shreg_ff <= work >> 7;
                  phase_ff <= cur_phase;
                  last_ff  <= 1'b0;
                  state_ff <= ST_BUSY;
               end else if (!cur_phase && cur_has_val) begin
                  shreg_ff <= cur_value;
                  phase_ff <= 1'b1;
                  last_ff  <= 1'b0;
                  state_ff <= ST_BUSY;
               end else begin
                  last_ff  <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_byte_count  = byte_count_ff;

endmodule

// ----- sv/protobuf_field_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_encoder
// serializes protobuf wire-format fields into a bounded output buffer
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  opcode, field_number, value, byte
//  rsp_     out        rsp_valid/rsp_ready  out_byte, last, overflow, count
//  csr_     in         csr_valid/csr_ready  capacity (17 bits)
//
//  one output word per cycle from the back sequencer while rsp_ready is high;
//  a payload byte emits one word, a header one word per tag and value varint
//  byte (up to 15); a start word emits nothing
//  reset is synchronous; capacity returns to 65536, count and error clear
//  the two-entry queue lets req_ accept up to two words while rsp_ stalls
// ----------------------------------------------------------------------------
module protobuf_field_encoder #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [pfe_pkg::FIELD_W-1:0] req_field_number,
   input  logic [pfe_pkg::VALUE_W-1:0] req_value,
   input  logic [7:0]                  req_payload_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_overflow,
   output logic [pfe_pkg::CNT_W-1:0]   rsp_byte_count,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pfe_pkg::CNT_W-1:0]   csr_data
);
   import pfe_pkg::*;

   logic [CNT_W-1:0] capacity_ff;
   entry_type        front_entry;
   entry_type        head;
   logic             head_valid, head_ready;

   // capacity register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   // front: classify and build the tag
   pfe_front u_front (
      .req_opcode       (req_opcode),
      .req_field_number (req_field_number),
      .req_value        (req_value),
      .req_payload_byte (req_payload_byte),
      .entry            (front_entry)
   );

   // queue decouples intake from the byte sequencer
   pfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_data   (head)
   );

   // back: varint bytes, capacity check, sticky error
   pfe_back #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .capacity        (capacity_ff),
      .head_valid      (head_valid),
      .head_ready      (head_ready),
      .head            (head),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_overflow    (rsp_overflow),
      .rsp_byte_count  (rsp_byte_count)
   );

endmodule

// ----- sv/pfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker
// port-level checks on the encoder result channel
// ----------------------------------------------------------------------------
module pfe_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [7:0]                  rsp_out_byte,
   input logic                        rsp_last_of_run,
   input logic                        rsp_overflow,
   input logic [pfe_pkg::CNT_W-1:0]   rsp_byte_count
);

   // overflow word carries no byte
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_out_byte == 8'd0)
      else $error("overflow word with nonzero byte");

   // overflow always ends the run
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_last_of_run)
      else $error("overflow word not last of run");

   // a written byte counts itself
   a_count_nz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |-> rsp_byte_count != '0)
      else $error("data word with zero byte count");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_byte_count) && $stable(rsp_overflow))
      else $error("stalled word changed");

endmodule

bind protobuf_field_encoder pfe_checker u_pfe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_overflow    (rsp_overflow),
   .rsp_byte_count  (rsp_byte_count)
);
